// File: rtl/bwm_pkg.sv
package bwm_pkg;

    localparam int SLOTS = 100;
    localparam int BANKS = 2;
    localparam int DEPTH = BANKS * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int CW    = 32;
    localparam int SUM_W = 40;
    localparam int AVG_W = SUM_W + 3;
    localparam int DIV_CW = $clog2(AVG_W);
    localparam int LANES = 3;

    localparam logic [CW-1:0]   CNT_MAX = '1;
    localparam logic [CW-1:0]   SLOTS_W = CW'(SLOTS);
    localparam logic [AW-1:0]   SLOTS_A = AW'(SLOTS);
    localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SLOTS);
    localparam logic [63:0]     RECIP64 = (64'd1 << 32) / SLOTS;
    localparam logic [CW-1:0]   RECIP   = RECIP64[CW-1:0];

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;

    typedef struct packed {
        logic        mode;
        logic        minute_parity;
        logic [15:0] frame_size;
        logic [1:0]  direction;
        logic [31:0] packet_second;
    } bwm_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_total;
        logic [SUM_W-1:0] sum_up;
        logic [SUM_W-1:0] sum_down;
        logic [CW-1:0]    peak_total;
        logic [CW-1:0]    peak_up;
        logic [CW-1:0]    peak_down;
        logic [AVG_W-1:0] avg_total_bits;
        logic [AVG_W-1:0] avg_up_bits;
        logic [AVG_W-1:0] avg_down_bits;
    } bwm_out_t;

    typedef struct packed {
        logic [CW-1:0] total;
        logic [CW-1:0] up;
        logic [CW-1:0] down;
    } slot_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC_IDX,
        ST_REC_WRITE,
        ST_SWEEP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } bwm_state_t;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [15:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {{(CW - 15){1'b0}}, b};
        return s[CW] ? CNT_MAX : s[CW-1:0];
    endfunction

endpackage

// File: rtl/per_second_bandwidth_meter_core.sv
// Record: busy after the transfer through the 3-stage slot index, RAM read and write back;
// a new record is taken only once busy is low again after the write back.
// Report: a sweep over the SLOTS entries of one bank, then the three averages in turn in the
// shared divider, then one cycle with done high.
// Reset: a clearing pass writes zero to all 2*SLOTS RAM entries, busy high.
// Results are strobed by done for one cycle; the receiver cannot stall.
module per_second_bandwidth_meter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bwm_pkg::bwm_in_t  cmd,
    output logic              busy,
    output logic              done,
    output bwm_pkg::bwm_out_t result
);

    import bwm_pkg::*;

    bwm_state_t state_reg, state_next;

    logic             accept;
    bwm_in_t          cmd_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic [AW-1:0]    rec_addr_reg;
    logic [AW-1:0]    sweep_base_reg;
    logic [CNTW-1:0]  sw_cnt_reg;
    logic             rd_pend_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic [1:0]       div_sel_reg;

    logic [SUM_W-1:0] sum_reg  [LANES];
    logic [CW-1:0]    peak_reg [LANES];
    logic [CNTW-1:0]  nz_reg   [LANES];
    logic [AVG_W-1:0] avg_reg  [LANES];
    logic [CW-1:0]    lane_val [LANES];

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    slot_word_t       ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    slot_word_t       ram_rdata;
    logic [AW-1:0]    sweep_addr;
    logic             sweep_issue;
    slot_word_t       rec_word;

    logic             sidx_start;
    logic             sidx_valid;
    logic [AW-1:0]    sidx_index;

    logic             div_start;
    logic             div_done;
    logic [AVG_W-1:0] div_quo;
    logic [AVG_W-1:0] div_dividend;
    logic [CNTW-1:0]  div_divisor;

    assign accept = start && !busy;

    bwm_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    bwm_slot_index u_sidx (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (sidx_start),
        .bank          (cmd.minute_parity),
        .packet_second (cmd.packet_second),
        .valid         (sidx_valid),
        .index         (sidx_index)
    );

    bwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign div_dividend = {sum_reg[div_sel_reg], 3'b000};
    assign div_divisor  = nz_reg[div_sel_reg];

    assign sweep_addr  = sweep_base_reg + AW'(sw_cnt_reg);
    assign sweep_issue = sw_cnt_reg != SLOTS_C;

    assign lane_val[0] = ram_rdata.total;
    assign lane_val[1] = ram_rdata.up;
    assign lane_val[2] = ram_rdata.down;

    always_comb
    begin
        rec_word       = ram_rdata;
        rec_word.total = sat_add(ram_rdata.total, cmd_reg.frame_size);
        if (cmd_reg.direction == DIR_UP)
        begin
            rec_word.up = sat_add(ram_rdata.up, cmd_reg.frame_size);
        end
        if (cmd_reg.direction == DIR_DOWN)
        begin
            rec_word.down = sat_add(ram_rdata.down, cmd_reg.frame_size);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd.mode == MODE_REPORT) ? ST_SWEEP : ST_REC_IDX;
                end
            end
            ST_REC_IDX:
            begin
                if (sidx_valid)
                begin
                    state_next = ST_REC_WRITE;
                end
            end
            ST_REC_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (!sweep_issue && !rd_pend_reg)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_sel_reg == 2'd2) ? ST_DONE : ST_DIV_START;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = rd_addr_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = sweep_addr;
        sidx_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                sidx_start = start && (cmd.mode == MODE_RECORD);
            end
            ST_REC_IDX:
            begin
                ram_re    = sidx_valid;
                ram_raddr = sidx_index;
            end
            ST_REC_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = rec_addr_reg;
                ram_wdata = rec_word;
            end
            ST_SWEEP:
            begin
                ram_re = sweep_issue;
                ram_we = rd_pend_reg;
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            sw_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            div_sel_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                sw_cnt_reg  <= '0;
                div_sel_reg <= '0;
            end
            if (state_reg == ST_SWEEP)
            begin
                rd_pend_reg <= sweep_issue;
                if (sweep_issue)
                begin
                    sw_cnt_reg <= sw_cnt_reg + 1'b1;
                end
            end
            if (state_reg == ST_DIV_WAIT && div_done)
            begin
                div_sel_reg <= div_sel_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= cmd;
            sweep_base_reg <= cmd.minute_parity ? '0 : SLOTS_A;
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i]  <= '0;
                peak_reg[i] <= '0;
                nz_reg[i]   <= '0;
            end
        end
        if (state_reg == ST_REC_IDX && sidx_valid)
        begin
            rec_addr_reg <= sidx_index;
        end
        if (state_reg == ST_SWEEP)
        begin
            rd_addr_reg <= sweep_addr;
            if (rd_pend_reg)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(lane_val[i]);
                    if (lane_val[i] > peak_reg[i])
                    begin
                        peak_reg[i] <= lane_val[i];
                    end
                    if (lane_val[i] != '0)
                    begin
                        nz_reg[i] <= nz_reg[i] + 1'b1;
                    end
                end
            end
        end
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            avg_reg[div_sel_reg] <= (nz_reg[div_sel_reg] == '0) ? '0 : div_quo;
        end
    end

    assign result.sum_total      = sum_reg[0];
    assign result.sum_up         = sum_reg[1];
    assign result.sum_down       = sum_reg[2];
    assign result.peak_total     = peak_reg[0];
    assign result.peak_up        = peak_reg[1];
    assign result.peak_down      = peak_reg[2];
    assign result.avg_total_bits = avg_reg[0];
    assign result.avg_up_bits    = avg_reg[1];
    assign result.avg_down_bits  = avg_reg[2];

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("RAM read and write hit the same entry");

    a_sweep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && state_reg == ST_SWEEP |-> ram_wdata == '0)
        else $error("sweep write-back is not zero");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside of wait state");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

endmodule

// File: rtl/bwm_ram.sv
module bwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/bwm_slot_index.sv
module bwm_slot_index (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 bank,
    input  logic [31:0]          packet_second,
    output logic                 valid,
    output logic [bwm_pkg::AW-1:0] index
);

    import bwm_pkg::*;

    logic          v1_reg, v2_reg, v3_reg;
    logic          b1_reg, b2_reg;
    logic [CW-1:0] x1_reg, x2_reg;
    logic [CW-1:0] q_reg;
    logic [CW-1:0] qs_reg;
    logic [AW-1:0] index_reg;
    logic [63:0]   prod;
    logic [CW-1:0] r_est;
    logic [CW-1:0] r_fix;
    logic [AW-1:0] index_next;

    assign prod = 64'(packet_second) * 64'(RECIP);

    always_comb
    begin
        r_est = x2_reg - qs_reg;
        r_fix = (r_est >= SLOTS_W) ? r_est - SLOTS_W : r_est;
        index_next = b2_reg ? SLOTS_A + AW'(r_fix) : AW'(r_fix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x1_reg <= packet_second;
            b1_reg <= bank;
            q_reg  <= prod[63:32];
        end
        if (v1_reg)
        begin
            x2_reg <= x1_reg;
            b2_reg <= b1_reg;
            qs_reg <= CW'(q_reg * SLOTS_W);
        end
        if (v2_reg)
        begin
            index_reg <= index_next;
        end
    end

    assign valid = v3_reg;
    assign index = index_reg;

endmodule

// File: rtl/bwm_div.sv
module bwm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bwm_pkg::AVG_W-1:0] dividend,
    input  logic [bwm_pkg::CNTW-1:0]  divisor,
    output logic                      done,
    output logic [bwm_pkg::AVG_W-1:0] quotient
);

    import bwm_pkg::*;

    localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(AVG_W - 1);

    logic              active_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] step_reg;
    logic [CNTW-1:0]   div_reg;
    logic [CNTW-1:0]   rem_reg;
    logic [AVG_W-1:0]  quo_reg;
    logic [CNTW:0]     rem_sh;
    logic              take;
    logic [CNTW-1:0]   rem_next;
    logic [AVG_W-1:0]  quo_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[AVG_W-1]};
        take     = rem_sh >= {1'b0, div_reg};
        rem_next = take ? CNTW'(rem_sh - {1'b0, div_reg}) : rem_sh[CNTW-1:0];
        quo_next = {quo_reg[AVG_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= LAST_STEP;
            end
            else if (active_reg)
            begin
                if (step_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
